// File: rtl/lce_pkg.sv
// Shared types and constants for the linear convolution engine.
// No dependencies; every other file refers to this package by scoped names.
package lce_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SUM_BITS       = 37;
    localparam int TAP_COUNT_BITS = 6;
    localparam int TAP_INDEX_BITS = 5;

    // item kinds
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                             kind;
        logic [TAP_INDEX_BITS-1:0]        tap_index;
        logic signed [SAMPLE_BITS-1:0]    value;
        logic                             last;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       end_of_sequence;
    } out_word_t;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic                          shift;
        logic                          clear;
        logic                          tap_write;
        logic signed [SAMPLE_BITS-1:0] sample;
    } line_ctl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

// File: rtl/lce_cell.sv
// One cell of the convolution chain: a kernel tap, one delay-line sample
// and one stage of the partial-sum chain. Depends on lce_pkg.
module lce_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lce_pkg::line_ctl_t                     ctl,
    input  logic                                   tap_we,
    input  logic                                   active,
    input  logic signed [lce_pkg::SAMPLE_BITS-1:0] tap_value,
    input  logic signed [lce_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic signed [lce_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic signed [lce_pkg::SUM_BITS-1:0]    psum_in,
    output logic signed [lce_pkg::SUM_BITS-1:0]    psum_out
);

    logic signed [lce_pkg::SAMPLE_BITS-1:0]   tap_reg;
    logic signed [lce_pkg::SAMPLE_BITS-1:0]   smp_reg;
    logic signed [lce_pkg::SUM_BITS-1:0]      psum_reg;
    logic signed [lce_pkg::SUM_BITS-1:0]      psum_next;
    logic signed [2*lce_pkg::SAMPLE_BITS-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            smp_reg <= '0;
        end
        else
        begin
            if (tap_we)
            begin
                tap_reg <= tap_value;
            end
            if (ctl.clear)
            begin
                smp_reg <= '0;
            end
            else if (ctl.shift)
            begin
                smp_reg <= sample_in;
            end
        end
    end

    assign prod = tap_reg * smp_reg;

    // taps beyond the kernel length add nothing
    always_comb
    begin
        psum_next = psum_in;
        if (active)
        begin
            psum_next = psum_in + lce_pkg::SUM_BITS'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg <= psum_next;
    end

    assign sample_out = smp_reg;
    assign psum_out   = psum_reg;

endmodule

// File: rtl/lce_ctrl.sv
// Sequencer of the convolution engine: input handshake, tap_count register,
// tail counting, partial-sum wave timing and the result register. Uses lce_pkg.
module lce_ctrl #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  lce_pkg::in_word_t                      item,
    input  logic                                   tap_count_we,
    input  logic [lce_pkg::TAP_COUNT_BITS-1:0]     tap_count_wdata,
    output logic [lce_pkg::TAP_COUNT_BITS-1:0]     taps_used,
    output lce_pkg::line_ctl_t                     line_ctl,
    input  logic signed [lce_pkg::SUM_BITS-1:0]    chain_sum,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output lce_pkg::out_word_t                     result
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int TCW   = lce_pkg::TAP_COUNT_BITS;

    lce_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TCW-1:0]     tail_reg, tail_next;
    logic               seq_end_reg, seq_end_next;
    logic [TCW-1:0]     tap_count_reg;
    logic               out_valid_reg, out_valid_next;
    lce_pkg::out_word_t out_reg, out_next;

    logic [TCW-1:0]     tc_eff;
    logic               item_take;
    logic               wave_done;
    logic               finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TCW'(1);
        end
        else if (tap_count_we)
        begin
            tap_count_reg <= tap_count_wdata;
        end
    end

    // zero counts as one tap; saturate at the chain length
    always_comb
    begin
        tc_eff = (tap_count_reg == '0) ? TCW'(1) : tap_count_reg;
        taps_used = tc_eff;
        if (32'(tc_eff) > 32'(MAX_TAPS))
        begin
            taps_used = TCW'(MAX_TAPS);
        end
    end

    assign item_stall = (state_reg != lce_pkg::ST_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign wave_done  = (state_reg == lce_pkg::ST_RUN) && (cnt_reg == CNT_W'(MAX_TAPS));
    assign finish     = wave_done && (!out_valid_reg || !result_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lce_pkg::ST_IDLE:
            begin
                if (item_take && item.kind == lce_pkg::KIND_SAMPLE)
                begin
                    state_next = lce_pkg::ST_RUN;
                end
            end
            lce_pkg::ST_RUN:
            begin
                if (finish && tail_reg == '0)
                begin
                    state_next = lce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lce_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        cnt_next           = cnt_reg;
        tail_next          = tail_reg;
        seq_end_next       = seq_end_reg;
        out_valid_next     = out_valid_reg && result_stall;
        out_next           = out_reg;
        line_ctl.shift     = 1'b0;
        line_ctl.clear     = 1'b0;
        line_ctl.tap_write = 1'b0;
        line_ctl.sample    = '0;
        case (state_reg)
            lce_pkg::ST_IDLE:
            begin
                if (item_take)
                begin
                    if (item.kind == lce_pkg::KIND_SAMPLE)
                    begin
                        line_ctl.shift  = 1'b1;
                        line_ctl.sample = item.value;
                        cnt_next        = '0;
                        seq_end_next    = item.last;
                        tail_next       = item.last ? (taps_used - TCW'(1)) : '0;
                    end
                    else
                    begin
                        line_ctl.tap_write = 1'b1;
                    end
                end
            end
            lce_pkg::ST_RUN:
            begin
                if (!wave_done)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (finish)
                begin
                    out_valid_next              = 1'b1;
                    out_next.sum                = chain_sum;
                    out_next.end_of_sequence    = seq_end_reg && (tail_reg == '0);
                    if (tail_reg != '0)
                    begin
                        // push a zero for the next tail word
                        line_ctl.shift = 1'b1;
                        tail_next      = tail_reg - TCW'(1);
                        cnt_next       = '0;
                    end
                    else
                    begin
                        line_ctl.clear = seq_end_reg;
                        seq_end_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lce_pkg::ST_IDLE;
            cnt_reg       <= '0;
            tail_reg      <= '0;
            seq_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tail_reg      <= tail_next;
            seq_end_reg   <= seq_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_idle_no_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lce_pkg::ST_IDLE) |-> (tail_reg == '0 && !seq_end_reg))
        else $error("tail pending while idle");

    a_clear_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(line_ctl.clear && line_ctl.shift))
        else $error("delay line cleared and shifted together");

    a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && tail_reg != '0) |=>
            (state_reg == lce_pkg::ST_RUN && cnt_reg == '0 &&
             tail_reg == $past(tail_reg) - TCW'(1)))
        else $error("tail word did not restart the wave");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lce_pkg::ST_RUN && wave_done))
        else $error("result raised without a finished wave");

    a_sample_starts_wave: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.kind == lce_pkg::KIND_SAMPLE) |=>
            (state_reg == lce_pkg::ST_RUN && cnt_reg == '0))
        else $error("sample did not start a wave");
`endif

endmodule

// File: rtl/linear_convolution_engine.sv
// Streaming full linear convolution built as a chain of tap cells.
// Depends on lce_pkg, lce_cell and lce_ctrl.
//
// Kernel taps are loaded with tap items (kind 0) and take effect at once;
// sample items (kind 1) shift a Q1.15 sample into a MAX_TAPS-long delay line
// and yield one exact Q7.30 sum of tap times delayed sample. A sample marked
// last is followed by taps_used-1 tail words computed with zeros shifted in;
// the final word carries end_of_sequence and the delay line is then cleared.
// Each sum is formed by a wave of partial sums that walks the whole chain,
// one cell per clock. A sample item stalls the input until its result word
// is written and any tail words are done; tap items do not stall it. A
// finished word waits in the output register while the next sample is
// accepted. tap_count is to be written by the user only while the engine is
// idle; the block itself does not enforce this.
module linear_convolution_engine #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  lce_pkg::in_word_t                      item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output lce_pkg::out_word_t                     result,
    input  logic                                   tap_count_we,
    input  logic [lce_pkg::TAP_COUNT_BITS-1:0]     tap_count_wdata
);

    lce_pkg::line_ctl_t                     line_ctl;
    logic [lce_pkg::TAP_COUNT_BITS-1:0]     taps_used;
    logic signed [lce_pkg::SAMPLE_BITS-1:0] smp_link [MAX_TAPS+1];
    logic signed [lce_pkg::SUM_BITS-1:0]    psum_link [MAX_TAPS+1];

    lce_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .tap_count_we    (tap_count_we),
        .tap_count_wdata (tap_count_wdata),
        .taps_used       (taps_used),
        .line_ctl        (line_ctl),
        .chain_sum       (psum_link[MAX_TAPS]),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result)
    );

    assign smp_link[0]  = line_ctl.sample;
    assign psum_link[0] = '0;

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        logic tap_we;
        logic active;

        // an index past the chain matches no cell and is dropped
        assign tap_we = line_ctl.tap_write && (32'(item.tap_index) == j);
        assign active = (j < 32'(taps_used));

        lce_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (line_ctl),
            .tap_we     (tap_we),
            .active     (active),
            .tap_value  (item.value),
            .sample_in  (smp_link[j]),
            .sample_out (smp_link[j+1]),
            .psum_in    (psum_link[j]),
            .psum_out   (psum_link[j+1])
        );
    end

endmodule
